// ----- src/ntsc_pkg.sv -----
package ntsc_pkg;

  // Item kinds on the input channel
  localparam logic [1:0] KIND_TICK     = 2'd0;
  localparam logic [1:0] KIND_CONFIRM  = 2'd1;
  localparam logic [1:0] KIND_RESPONSE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_RETRY_DELAY    = 2'd1;
  localparam logic [1:0] CFG_CONFIRM_WAIT   = 2'd2;

  // Markers and reset values
  localparam logic [15:0] NO_NEIGHBOR    = 16'hFFFF;
  localparam logic [7:0]  INVALID_WEEK   = 8'hFF;
  localparam logic [7:0]  RESET_WAIT     = 8'd2;
  localparam logic [7:0]  RETRY_DEFAULT  = 8'd10;
  localparam logic [7:0]  CONFIRM_DEFAULT = 8'd5;

  typedef enum logic [2:0] {
    PH_NEXT_LOOP = 3'd0,
    PH_DISC_SEND = 3'd1,
    PH_DISC_CONF = 3'd2,
    PH_SYNC_SEND = 3'd3,
    PH_SYNC_CONF = 3'd4,
    PH_SYNC_RESP = 3'd5
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  tick_wait;
    logic [15:0] neighbor;
    logic        time_valid;
  } sync_state_t;

  typedef struct packed {
    logic send_discovery;
    logic send_request;
    logic unexpected_confirm;
  } step_flags_t;

endpackage

// ----- src/ntsc_if.sv -----
interface ntsc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        send_ok;
  logic [7:0]  week_byte;
  logic [15:0] next_neighbor;

  modport source (output valid, kind, send_ok, week_byte, next_neighbor, input ready);
  modport sink   (input valid, kind, send_ok, week_byte, next_neighbor, output ready);
endinterface

interface ntsc_out_if;
  logic        valid;
  logic        ready;
  logic        send_discovery;
  logic        send_request;
  logic [15:0] request_destination;
  logic [15:0] request_source;
  logic [2:0]  sync_state;
  logic [7:0]  wait_count;
  logic        datetime_valid;
  logic        unexpected_confirm;

  modport source (output valid, send_discovery, send_request, request_destination,
                  request_source, sync_state, wait_count, datetime_valid,
                  unexpected_confirm, input ready);
  modport sink   (input valid, send_discovery, send_request, request_destination,
                  request_source, sync_state, wait_count, datetime_valid,
                  unexpected_confirm, output ready);
endinterface

// ----- src/ntsc_step.sv -----
module ntsc_step
  import ntsc_pkg::*;
(
  input  sync_state_t st,
  input  logic [7:0]  retry_delay,
  input  logic [7:0]  confirm_wait,
  input  logic [1:0]  kind,
  input  logic        send_ok,
  input  logic [7:0]  week_byte,
  input  logic [15:0] next_neighbor,
  output sync_state_t st_nxt,
  output step_flags_t flags
);

  // Work out the state after one item
  always_comb begin
    st_nxt = st;
    flags  = '0;
    unique case (kind)
      KIND_TICK: begin
        if (!st.time_valid) begin
          if (st.tick_wait != 8'd0) begin
            st_nxt.tick_wait = st.tick_wait - 8'd1;
          end else begin
            unique case (st.phase)
              PH_NEXT_LOOP: st_nxt.phase = PH_DISC_SEND;
              PH_DISC_SEND: begin
                flags.send_discovery = 1'b1;
                st_nxt.phase = PH_DISC_CONF;
              end
              PH_SYNC_RESP: st_nxt.phase = PH_SYNC_SEND;
              PH_SYNC_SEND: begin
                st_nxt.neighbor = next_neighbor;
                if (next_neighbor == NO_NEIGHBOR) begin
                  st_nxt.phase     = PH_NEXT_LOOP;
                  st_nxt.tick_wait = retry_delay;
                end else begin
                  flags.send_request = 1'b1;
                  st_nxt.phase = PH_SYNC_CONF;
                end
              end
              default: ;
            endcase
          end
        end
      end
      KIND_CONFIRM: begin
        unique case (st.phase)
          PH_DISC_CONF: begin
            if (send_ok) begin
              st_nxt.tick_wait = confirm_wait;
              st_nxt.phase     = PH_SYNC_SEND;
            end else begin
              st_nxt.phase = PH_DISC_SEND;
            end
          end
          PH_SYNC_CONF: begin
            if (send_ok) begin
              st_nxt.tick_wait = confirm_wait;
              st_nxt.phase     = PH_SYNC_RESP;
            end else begin
              st_nxt.phase = PH_DISC_SEND;
            end
          end
          default: flags.unexpected_confirm = 1'b1;
        endcase
      end
      KIND_RESPONSE: begin
        if (st.phase == PH_SYNC_RESP) begin
          if (week_byte != INVALID_WEEK) begin
            st_nxt.time_valid = 1'b1;
          end else begin
            st_nxt.phase     = PH_SYNC_SEND;
            st_nxt.tick_wait = 8'd0;
          end
        end
      end
      // Unused kind: hold the state
      default: ;
    endcase
  end

endmodule

// ----- src/neighbor_time_sync_controller_unit.sv -----
// Neighbour time synchronisation controller.
// in_item carries one event per item: a one-second tick (with the
// neighbour-table answer for the current neighbour), a send confirmation
// (with its ok bit) or a sync response (with its weekday byte).
// out_item gives exactly one result per item: discovery and request
// commands, request addresses, the phase, the wait count and the
// date-time-valid flag, all as they stand after that item.
// The result is registered: it is valid in the cycle after its item is
// accepted. Throughput is one item per cycle while the receiver does not
// stall; the state update is a single compare, decrement and
// select between the state registers. in_item.ready is high whenever the
// result register is empty or being emptied, so a stalled receiver holds
// the result and blocks new items only while it keeps ready low.
// The cfg_ port writes device_address, retry_delay and confirm_wait by
// index; write it only while no item is in flight.
// Synchronous reset clears the result valid flag and returns the controller
// to the next-loop phase with a wait of two ticks and no valid time.
module neighbor_time_sync_controller_unit
  import ntsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  ntsc_in_if.sink     in_item,
  ntsc_out_if.source  out_item,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  sync_state_t st_r, st_nxt;
  step_flags_t flags;
  logic [15:0] device_address_r;
  logic [7:0]  retry_delay_r;
  logic [7:0]  confirm_wait_r;

  logic        out_valid_r;
  step_flags_t res_flags_r;
  sync_state_t res_state_r;
  logic [15:0] res_source_r;
  logic        accept;

  assign in_item.ready = !out_valid_r || out_item.ready;
  assign accept = in_item.valid && in_item.ready;

  ntsc_step u_step (
    .st            (st_r),
    .retry_delay   (retry_delay_r),
    .confirm_wait  (confirm_wait_r),
    .kind          (in_item.kind),
    .send_ok       (in_item.send_ok),
    .week_byte     (in_item.week_byte),
    .next_neighbor (in_item.next_neighbor),
    .st_nxt        (st_nxt),
    .flags         (flags)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_address_r <= 16'd0;
      retry_delay_r    <= RETRY_DEFAULT;
      confirm_wait_r   <= CONFIRM_DEFAULT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEVICE_ADDRESS: device_address_r <= cfg_wdata;
        CFG_RETRY_DELAY:    retry_delay_r    <= cfg_wdata[7:0];
        CFG_CONFIRM_WAIT:   confirm_wait_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Advance the controller state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase      <= PH_NEXT_LOOP;
      st_r.tick_wait  <= RESET_WAIT;
      st_r.neighbor   <= 16'd0;
      st_r.time_valid <= 1'b0;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

  // Result valid: set on accept, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_item.ready) begin
      out_valid_r <= accept;
    end
  end

  // Hold the result payload until taken
  always_ff @(posedge clk) begin
    if (accept) begin
      res_flags_r  <= flags;
      res_state_r  <= st_nxt;
      res_source_r <= device_address_r;
    end
  end

  assign out_item.valid               = out_valid_r;
  assign out_item.send_discovery      = res_flags_r.send_discovery;
  assign out_item.send_request        = res_flags_r.send_request;
  assign out_item.request_destination = res_state_r.neighbor;
  assign out_item.request_source      = res_source_r;
  assign out_item.sync_state          = res_state_r.phase;
  assign out_item.wait_count          = res_state_r.tick_wait;
  assign out_item.datetime_valid      = res_state_r.time_valid;
  assign out_item.unexpected_confirm  = res_flags_r.unexpected_confirm;

endmodule

// ----- test/neighbor_time_sync_controller_unit_test.sv -----
module neighbor_time_sync_controller_unit_test;
  import ntsc_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]  kind;
    logic        send_ok;
    logic [7:0]  week_byte;
    logic [15:0] next_neighbor;
  } sync_item_t;

  typedef struct packed {
    logic        send_discovery;
    logic        send_request;
    logic [15:0] request_destination;
    logic [15:0] request_source;
    logic [2:0]  sync_state;
    logic [7:0]  wait_count;
    logic        datetime_valid;
    logic        unexpected_confirm;
  } sync_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  ntsc_in_if  in_ch ();
  ntsc_out_if out_ch ();

  neighbor_time_sync_controller_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_ch),
    .out_item  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Controller copy kept alongside the block
  phase_t      cur_phase;
  logic [7:0]  wait_left;
  logic [15:0] neighbor;
  logic        time_ok;
  logic [15:0] own_address;
  logic [7:0]  retry_ticks;
  logic [7:0]  confirm_ticks;

  sync_result_t due_results[$];
  sync_result_t got_result;
  sync_result_t want_result;
  int           mismatch_count = 0;
  int           cycles = 0;
  bit           gaps_on = 1'b1;
  bit           stalls_on = 1'b1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Apply one item to the controller copy and give the result it yields
  function automatic sync_result_t sync_step(input sync_item_t it);
    sync_result_t r;
    r = '0;
    case (it.kind)
      KIND_TICK: begin
        if (!time_ok) begin
          if (wait_left != 8'd0) begin
            wait_left = wait_left - 8'd1;
          end else begin
            case (cur_phase)
              PH_NEXT_LOOP: cur_phase = PH_DISC_SEND;
              PH_DISC_SEND: begin
                r.send_discovery = 1'b1;
                cur_phase = PH_DISC_CONF;
              end
              PH_SYNC_RESP: cur_phase = PH_SYNC_SEND;
              PH_SYNC_SEND: begin
                neighbor = it.next_neighbor;
                if (it.next_neighbor == NO_NEIGHBOR) begin
                  cur_phase = PH_NEXT_LOOP;
                  wait_left = retry_ticks;
                end else begin
                  r.send_request = 1'b1;
                  cur_phase = PH_SYNC_CONF;
                end
              end
              default: ;
            endcase
          end
        end
      end
      KIND_CONFIRM: begin
        if (cur_phase == PH_DISC_CONF || cur_phase == PH_SYNC_CONF) begin
          if (it.send_ok) begin
            wait_left = confirm_ticks;
            cur_phase = (cur_phase == PH_DISC_CONF) ? PH_SYNC_SEND : PH_SYNC_RESP;
          end else begin
            cur_phase = PH_DISC_SEND;
          end
        end else begin
          r.unexpected_confirm = 1'b1;
        end
      end
      KIND_RESPONSE: begin
        if (cur_phase == PH_SYNC_RESP) begin
          if (it.week_byte != INVALID_WEEK) begin
            time_ok = 1'b1;
          end else begin
            cur_phase = PH_SYNC_SEND;
            wait_left = 8'd0;
          end
        end
      end
      default: ;
    endcase
    r.request_destination = neighbor;
    r.request_source      = own_address;
    r.sync_state          = cur_phase;
    r.wait_count          = wait_left;
    r.datetime_valid      = time_ok;
    return r;
  endfunction

  function automatic sync_item_t event_item(input logic [1:0] kind, input logic ok,
                                            input logic [7:0] week,
                                            input logic [15:0] next);
    sync_item_t it;
    it.kind = kind;
    it.send_ok = ok;
    it.week_byte = week;
    it.next_neighbor = next;
    return it;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap(input bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Build a random item, mostly one that the current phase is waiting for
  function automatic sync_item_t random_event(input bit allow_valid);
    sync_item_t it;
    it = sync_item_t'($urandom);
    if ($urandom_range(0, 99) < 80) begin
      case (cur_phase)
        PH_DISC_CONF, PH_SYNC_CONF: begin
          it.kind = ($urandom_range(0, 99) < 25) ? KIND_TICK : KIND_CONFIRM;
          it.send_ok = ($urandom_range(0, 99) < 85);
        end
        PH_SYNC_RESP: begin
          if ($urandom_range(0, 99) < ((wait_left != 8'd0) ? 70 : 50))
            it.kind = KIND_TICK;
          else
            it.kind = KIND_RESPONSE;
          if (allow_valid && $urandom_range(0, 99) < 30) it.week_byte = INVALID_WEEK;
        end
        default: it.kind = KIND_TICK;
      endcase
      if ($urandom_range(0, 99) < 25) it.next_neighbor = NO_NEIGHBOR;
    end
    // Keep the time invalid until the phase that is meant to set it
    if (!allow_valid && it.kind == KIND_RESPONSE && cur_phase == PH_SYNC_RESP)
      it.week_byte = INVALID_WEEK;
    return it;
  endfunction

  // Offer one item, hold it until taken, then idle for a random gap, maybe none
  task automatic send_item(input sync_item_t it);
    int gap;
    @(negedge clk);
    in_ch.valid         <= 1'b1;
    in_ch.kind          <= it.kind;
    in_ch.send_ok       <= it.send_ok;
    in_ch.week_byte     <= it.week_byte;
    in_ch.next_neighbor <= it.next_neighbor;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    due_results.push_back(sync_step(it));
    gap = pick_gap(gaps_on);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
  endtask

  // Drop valid and wait for every outstanding result, plus the pipeline delay
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_DEVICE_ADDRESS: own_address = data;
      CFG_RETRY_DELAY:    retry_ticks = data[7:0];
      CFG_CONFIRM_WAIT:   confirm_ticks = data[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [15:0] addr, input logic [7:0] retry,
                            input logic [7:0] confirm);
    settle();
    write_reg(CFG_DEVICE_ADDRESS, addr);
    write_reg(CFG_RETRY_DELAY, {8'h00, retry});
    write_reg(CFG_CONFIRM_WAIT, {8'h00, confirm});
  endtask

  task automatic run_random(input int count, input bit allow_valid);
    repeat (count) begin
      if ($urandom_range(0, 199) == 0) settle();
      send_item(random_event(allow_valid));
    end
  endtask

  // Items that change nothing at reset: unused kind, stray confirmation, early response
  task automatic test_idle_items();
    send_item(event_item(KIND_UNUSED, 1'b1, 8'hFF, 16'hFFFF));
    send_item(event_item(KIND_CONFIRM, 1'b1, 8'h00, 16'h0000));
    send_item(event_item(KIND_RESPONSE, 1'b0, 8'h00, 16'h0000));
  endtask

  // Run down the reset wait, send discovery, fail once, then succeed
  task automatic test_discovery();
    set_config(16'hFFFF, 8'd0, 8'd0);
    repeat (4) send_item(event_item(KIND_TICK, 1'b0, 8'h00, 16'h1234));
    send_item(event_item(KIND_CONFIRM, 1'b0, 8'h00, 16'h0000));
    send_item(event_item(KIND_TICK, 1'b0, 8'h00, 16'h0000));
    send_item(event_item(KIND_CONFIRM, 1'b1, 8'h00, 16'h0000));
  endtask

  // Poll neighbours: timeout, last neighbour, failed request, invalid response
  task automatic test_neighbor_poll();
    send_item(event_item(KIND_TICK, 1'b0, 8'h00, 16'h0000));
    send_item(event_item(KIND_TICK, 1'b0, 8'h00, 16'h0000));
    send_item(event_item(KIND_CONFIRM, 1'b1, 8'h00, 16'h0000));
    send_item(event_item(KIND_TICK, 1'b0, 8'h00, 16'h0000));
    send_item(event_item(KIND_TICK, 1'b0, 8'h00, NO_NEIGHBOR));
    send_item(event_item(KIND_TICK, 1'b0, 8'h00, 16'h0000));
    send_item(event_item(KIND_TICK, 1'b0, 8'h00, 16'h0000));
    send_item(event_item(KIND_CONFIRM, 1'b1, 8'h00, 16'h0000));
    send_item(event_item(KIND_TICK, 1'b0, 8'h00, 16'hA5A5));
    send_item(event_item(KIND_CONFIRM, 1'b0, 8'h00, 16'h0000));
    send_item(event_item(KIND_TICK, 1'b0, 8'h00, 16'h0000));
    send_item(event_item(KIND_CONFIRM, 1'b1, 8'h00, 16'h0000));
    send_item(event_item(KIND_TICK, 1'b0, 8'h00, 16'h5A5A));
    send_item(event_item(KIND_CONFIRM, 1'b1, 8'h00, 16'h0000));
    send_item(event_item(KIND_RESPONSE, 1'b0, INVALID_WEEK, 16'h0000));
  endtask

  task automatic test_random_longest_waits();
    set_config(16'h0000, 8'hFF, 8'hFF);
    run_random(150, 1'b0);
  endtask

  task automatic test_random_short_waits();
    set_config(16'($urandom), 8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)));
    run_random(200, 1'b0);
  endtask

  // Full rate on both sides
  task automatic test_random_back_to_back();
    settle();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    set_config(16'($urandom), 8'd1, 8'd2);
    run_random(200, 1'b0);
    settle();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  task automatic test_random_default_waits();
    set_config(16'($urandom), RETRY_DEFAULT, CONFIRM_DEFAULT);
    run_random(150, 1'b0);
  endtask

  // Random items that may carry a valid response, after which ticks must change nothing
  task automatic test_time_valid();
    set_config(16'($urandom), 8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)));
    run_random(100, 1'b1);
  endtask

  // Receiver: stall now and then, mostly briefly
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (stalls_on && $urandom_range(0, 99) < 20) begin
        out_ch.ready <= 1'b0;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic note_mismatch(input string what, input sync_result_t want,
                               input sync_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t %s: want disc=%0b req=%0b dst=%h src=%h st=%0d wait=%0d val=%0b unexp=%0b, got disc=%0b req=%0b dst=%h src=%h st=%0d wait=%0d val=%0b unexp=%0b",
               $realtime, what,
               want.send_discovery, want.send_request, want.request_destination,
               want.request_source, want.sync_state, want.wait_count,
               want.datetime_valid, want.unexpected_confirm,
               got.send_discovery, got.send_request, got.request_destination,
               got.request_source, got.sync_state, got.wait_count,
               got.datetime_valid, got.unexpected_confirm);
  endtask

  // Compare each result taken with the oldest one due
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_result.send_discovery      = out_ch.send_discovery;
      got_result.send_request        = out_ch.send_request;
      got_result.request_destination = out_ch.request_destination;
      got_result.request_source      = out_ch.request_source;
      got_result.sync_state          = out_ch.sync_state;
      got_result.wait_count          = out_ch.wait_count;
      got_result.datetime_valid      = out_ch.datetime_valid;
      got_result.unexpected_confirm  = out_ch.unexpected_confirm;
      if (due_results.size() == 0) begin
        note_mismatch("result with none due", '0, got_result);
      end else begin
        want_result = due_results.pop_front();
        if (got_result !== want_result) note_mismatch("result mismatch", want_result, got_result);
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.kind          = KIND_TICK;
    in_ch.send_ok       = 1'b0;
    in_ch.week_byte     = 8'h00;
    in_ch.next_neighbor = 16'h0000;
    cfg_we              = 1'b0;
    cfg_index           = CFG_DEVICE_ADDRESS;
    cfg_wdata           = 16'h0000;
    rst_n               = 1'b0;
    own_address         = 16'h0000;
    retry_ticks         = RETRY_DEFAULT;
    confirm_ticks       = CONFIRM_DEFAULT;
    cur_phase           = PH_NEXT_LOOP;
    wait_left           = RESET_WAIT;
    neighbor            = 16'h0000;
    time_ok             = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_items();
    test_discovery();
    test_neighbor_poll();
    test_random_longest_waits();
    test_random_short_waits();
    test_random_back_to_back();
    test_random_default_waits();
    test_time_valid();

    settle();
    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
